// ----- src/mean_and_stdev_assert.svh -----
// Assertion macros for the mean and standard deviation block.
`ifndef MEAN_AND_STDEV_ASSERT_SVH
`define MEAN_AND_STDEV_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/msd_pkg.sv -----
// Shared widths, step counts and controller/datapath command types.
`default_nettype none

package msd_pkg;

   localparam int SAMPLE_W = 24;   // Q12.12 sample
   localparam int SUM_W    = 40;   // signed running sum
   localparam int SMAG_W   = 39;   // magnitude of the running sum
   localparam int SQ_W     = 47;   // one squared sample
   localparam int SQSUM_W  = 63;   // sum of squares
   localparam int CNT_W    = 16;   // sample count
   localparam int ACC_W    = 80;   // signed n*Q - S*S, also the dividend width
   localparam int DVSR_W   = 32;   // divisor, n*(n-1)
   localparam int RAD_W    = 64;   // square root radicand
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 3;
   localparam int STEP_W   = 7;

   localparam logic [CNT_W-1:0]  MAX_SAMPLES = 16'd65535;
   localparam logic [STEP_W-1:0] DIV_STEPS   = STEP_W'(ACC_W);
   localparam logic [STEP_W-1:0] NQ_STEPS    = STEP_W'(CNT_W);
   localparam logic [STEP_W-1:0] SS_STEPS    = STEP_W'(SMAG_W);
   localparam logic [STEP_W-1:0] SQRT_STEPS  = STEP_W'(ROOT_W);

   // Datapath operation selected by the controller
   typedef enum logic [2:0] {
      OP_NONE,
      OP_MEAN_DIV,
      OP_MEAN_FIX,
      OP_MUL_NQ,
      OP_MUL_SS,
      OP_VAR_DIV,
      OP_SQRT
   } op_type;

   typedef struct packed {
      logic   accum;      // input transaction accepted this cycle
      logic   init;       // first cycle of an operation: load operands
      logic   step;       // one iteration of the current operation
      op_type op;
      logic   load_out;   // capture results into the output register
   } cmd_type;

endpackage

`default_nettype wire

// ----- src/mean_and_stdev.sv -----
// Accumulation: one sample per cycle while the input is not stalled. After the last sample
// the input stalls while the mean divide, mean fix, n*Q, S*S, variance divide and square
// root run in that order, the divider and the multiplier each shared by two of them, before
// rsp_valid rises; a one-sample set goes from the mean fix straight to the result.
// Input accepts again once the result sits in the output register.
// Synchronous reset clears the accumulators, the sequencer and rsp_valid.
`default_nettype none
`include "mean_and_stdev_assert.svh"

module mean_and_stdev (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [msd_pkg::SAMPLE_W-1:0] req_sample_value,
   input  wire logic                                req_last_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [msd_pkg::SAMPLE_W-1:0]      rsp_mean_value,
   output logic [msd_pkg::SAMPLE_W-1:0]             rsp_stdev_value,
   output logic [msd_pkg::CNT_W-1:0]                rsp_samples_used,
   output logic                                     rsp_too_few,
   output logic                                     rsp_overflow
);

   msd_pkg::cmd_type cmd;
   logic             few;

   // Sequencer
   msd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .few             (few),
      .cmd             (cmd)
   );

   // Arithmetic
   msd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample_value (req_sample_value),
      .few              (few),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_stdev_value  (rsp_stdev_value),
      .rsp_samples_used (rsp_samples_used),
      .rsp_too_few      (rsp_too_few),
      .rsp_overflow     (rsp_overflow)
   );

   // Checks
   `MSD_ASSERT_NEXT(ast_last_stalls, clock, reset, req_valid && !req_stall && req_last_sample, req_stall, "input not stalled after last sample")
   `MSD_ASSERT_SAME(ast_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "result appeared without a compute phase")
   `MSD_ASSERT_SAME(ast_single_zero, clock, reset, rsp_valid && rsp_too_few, rsp_stdev_value == '0 && rsp_samples_used == 16'd1, "single-sample result malformed")
   `MSD_ASSERT_SAME(ast_ovf_full, clock, reset, rsp_valid && rsp_overflow, rsp_samples_used == msd_pkg::MAX_SAMPLES, "overflow flagged below the sample limit")

endmodule

`default_nettype wire

// ----- src/msd_ctrl.sv -----
// Controller: sequences accumulation, division, multiply and root steps.
`default_nettype none

module msd_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_last_sample,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire logic           few,
   output msd_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_MEAN_DIV,
      ST_MEAN_FIX,
      ST_MUL_NQ,
      ST_MUL_SS,
      ST_VAR_DIV,
      ST_SQRT,
      ST_FINISH
   } state_type;

   state_type                      state_ff, state_in;
   logic [msd_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                           accept;
   logic                           out_free;
   logic                           done;
   logic [msd_pkg::STEP_W-1:0]     limit;
   msd_pkg::op_type                op;

   assign accept   = req_valid && (state_ff == ST_ACCUM);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign done     = (step_ff == limit);

   // Operation and iteration count per state
   always_comb begin
      op    = msd_pkg::OP_NONE;
      limit = '0;
      unique case (state_ff) inside
         ST_MEAN_DIV: begin
            op    = msd_pkg::OP_MEAN_DIV;
            limit = msd_pkg::DIV_STEPS;
         end
         ST_MEAN_FIX: begin
            op    = msd_pkg::OP_MEAN_FIX;
         end
         ST_MUL_NQ: begin
            op    = msd_pkg::OP_MUL_NQ;
            limit = msd_pkg::NQ_STEPS;
         end
         ST_MUL_SS: begin
            op    = msd_pkg::OP_MUL_SS;
            limit = msd_pkg::SS_STEPS;
         end
         ST_VAR_DIV: begin
            op    = msd_pkg::OP_VAR_DIV;
            limit = msd_pkg::DIV_STEPS;
         end
         ST_SQRT: begin
            op    = msd_pkg::OP_SQRT;
            limit = msd_pkg::SQRT_STEPS;
         end
         ST_ACCUM, ST_FINISH: begin
            op    = msd_pkg::OP_NONE;
         end
         default: begin
            op    = msd_pkg::OP_NONE;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in     = state_ff;
      step_in      = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_ACCUM: begin
            if (accept && req_last_sample) begin
               state_in = ST_MEAN_DIV;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            if (!done) begin
               step_in = step_ff + 1'b1;
            end else begin
               unique case (state_ff)
                  ST_MEAN_DIV: state_in = ST_MEAN_FIX;
                  ST_MEAN_FIX: state_in = few ? ST_FINISH : ST_MUL_NQ;
                  ST_MUL_NQ:   state_in = ST_MUL_SS;
                  ST_MUL_SS:   state_in = ST_VAR_DIV;
                  ST_VAR_DIV:  state_in = ST_SQRT;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall    = (state_ff != ST_ACCUM);
   assign rsp_valid    = rsp_valid_ff;
   assign cmd.accum    = accept;
   assign cmd.init     = (step_ff == '0);
   assign cmd.step     = (step_ff != '0);
   assign cmd.op       = op;
   assign cmd.load_out = (state_ff == ST_FINISH) && out_free;

endmodule

`default_nettype wire

// ----- src/msd_dp.sv -----
// Datapath: accumulators, shift-add multiplier, restoring divider, square root.
`default_nettype none

module msd_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire msd_pkg::cmd_type                   cmd,
   input  wire logic signed [msd_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                                    few,
   output logic signed [msd_pkg::SAMPLE_W-1:0]     rsp_mean_value,
   output logic [msd_pkg::SAMPLE_W-1:0]            rsp_stdev_value,
   output logic [msd_pkg::CNT_W-1:0]               rsp_samples_used,
   output logic                                    rsp_too_few,
   output logic                                    rsp_overflow
);

   localparam int SAMPLE_W = msd_pkg::SAMPLE_W;
   localparam int SUM_W    = msd_pkg::SUM_W;
   localparam int SMAG_W   = msd_pkg::SMAG_W;
   localparam int SQ_W     = msd_pkg::SQ_W;
   localparam int SQSUM_W  = msd_pkg::SQSUM_W;
   localparam int CNT_W    = msd_pkg::CNT_W;
   localparam int ACC_W    = msd_pkg::ACC_W;
   localparam int DVSR_W   = msd_pkg::DVSR_W;
   localparam int RAD_W    = msd_pkg::RAD_W;
   localparam int ROOT_W   = msd_pkg::ROOT_W;
   localparam int REM_W    = msd_pkg::REM_W;

   // Accumulator state
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQSUM_W-1:0]  sqsum_ff, sqsum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic                sq_pend_ff, sq_pend_in;

   // Shift-add multiplier
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]    mcand_ff, mcand_in;
   logic [SMAG_W-1:0]   mplier_ff, mplier_in;
   logic [DVSR_W-1:0]   nn1_ff, nn1_in;

   // Restoring divider
   logic [ACC_W-1:0]    div_dq_ff, div_dq_in;
   logic [DVSR_W-1:0]   div_rem_ff, div_rem_in;
   logic [DVSR_W-1:0]   div_dvsr_ff, div_dvsr_in;

   // Digit-by-digit square root
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [REM_W-1:0]    sq_rem_ff, sq_rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic                stdev_ok_ff, stdev_ok_in;

   logic [SAMPLE_W-1:0] mean_ff, mean_in;

   // Output register
   logic [SAMPLE_W-1:0] out_mean_ff, out_mean_in;
   logic [SAMPLE_W-1:0] out_stdev_ff, out_stdev_in;
   logic [CNT_W-1:0]    out_used_ff, out_used_in;
   logic                out_few_ff, out_few_in;
   logic                out_ovf_ff, out_ovf_in;

   logic                    use_sample;
   logic [SUM_W-1:0]        sample_ext;
   logic [SQ_W-1:0]         sq_prod;
   logic [SUM_W-1:0]        sum_neg;
   logic [SMAG_W-1:0]       smag;
   logic [ACC_W-1:0]        mul_term;
   logic [DVSR_W:0]         div_shift;
   logic [DVSR_W+1:0]       div_diff;
   logic                    div_fit;
   logic [REM_W-1:0]        sqrt_shift;
   logic [REM_W-1:0]        sqrt_trial;
   logic [REM_W:0]          sqrt_diff;
   logic                    sqrt_fit;
   logic                    rem_zero;

   assign few = (count_ff[CNT_W-1:1] == '0);

   // Sample accumulation; squares are added in the cycle after acceptance
   always_comb begin
      sample_ext = {{(SUM_W-SAMPLE_W){req_sample_value[SAMPLE_W-1]}}, req_sample_value};
      // a square of a 24-bit sample always fits in 47 bits
      sq_prod    = SQ_W'(req_sample_value) * SQ_W'(req_sample_value);
      use_sample = cmd.accum && (count_ff != msd_pkg::MAX_SAMPLES);
      sum_in     = sum_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      sq_in      = sq_prod;
      sq_pend_in = use_sample;
      sqsum_in   = sq_pend_ff ? sqsum_ff + SQSUM_W'(sq_ff) : sqsum_ff;
      if (use_sample) begin
         sum_in   = sum_ff + sample_ext;
         count_in = count_ff + 1'b1;
      end
      if (cmd.accum && !use_sample) begin
         ovf_in = 1'b1;
      end
      if (cmd.load_out) begin
         sum_in   = '0;
         sqsum_in = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   // Magnitude of the running sum
   assign sum_neg = -sum_ff;
   assign smag    = sum_ff[SUM_W-1] ? sum_neg[SMAG_W-1:0] : sum_ff[SMAG_W-1:0];

   // Iteration terms
   assign mul_term   = mplier_ff[0] ? mcand_ff : '0;
   assign div_shift  = {div_rem_ff, div_dq_ff[ACC_W-1]};
   assign div_diff   = {1'b0, div_shift} - {2'b00, div_dvsr_ff};
   assign div_fit    = !div_diff[DVSR_W+1];
   assign sqrt_shift = {sq_rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign sqrt_trial = {1'b0, root_ff, 2'b01};
   assign sqrt_diff  = {1'b0, sqrt_shift} - {1'b0, sqrt_trial};
   assign sqrt_fit   = !sqrt_diff[REM_W];
   assign rem_zero   = (div_rem_ff == '0);

   // Multi-cycle operations
   always_comb begin
      acc_in      = acc_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      nn1_in      = nn1_ff;
      div_dq_in   = div_dq_ff;
      div_rem_in  = div_rem_ff;
      div_dvsr_in = div_dvsr_ff;
      rad_in      = rad_ff;
      sq_rem_in   = sq_rem_ff;
      root_in     = root_ff;
      stdev_ok_in = stdev_ok_ff;
      mean_in     = mean_ff;
      case (cmd.op) inside
         msd_pkg::OP_MEAN_DIV, msd_pkg::OP_VAR_DIV: begin
            if (cmd.init) begin
               div_rem_in = '0;
               if (cmd.op == msd_pkg::OP_MEAN_DIV) begin
                  div_dq_in   = ACC_W'(smag);
                  div_dvsr_in = DVSR_W'(count_ff);
                  stdev_ok_in = 1'b0;
               end else begin
                  div_dq_in   = acc_ff;
                  div_dvsr_in = nn1_ff;
               end
            end else if (cmd.step) begin
               div_dq_in  = {div_dq_ff[ACC_W-2:0], div_fit};
               div_rem_in = div_fit ? div_diff[DVSR_W-1:0] : div_shift[DVSR_W-1:0];
            end
         end
         msd_pkg::OP_MEAN_FIX: begin
            // floor for a negative sum: -(q + (r != 0)) = ~q + (r == 0)
            if (sum_ff[SUM_W-1]) begin
               mean_in = ~div_dq_ff[SAMPLE_W-1:0] + SAMPLE_W'(rem_zero);
            end else begin
               mean_in = div_dq_ff[SAMPLE_W-1:0];
            end
         end
         msd_pkg::OP_MUL_NQ: begin
            if (cmd.init) begin
               acc_in    = '0;
               mcand_in  = ACC_W'(sqsum_ff);
               mplier_in = SMAG_W'(count_ff);
               nn1_in    = DVSR_W'(count_ff) * DVSR_W'(count_ff - 1'b1);
            end else if (cmd.step) begin
               acc_in    = acc_ff + mul_term;
               mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[SMAG_W-1:1]};
            end
         end
         msd_pkg::OP_MUL_SS: begin
            if (cmd.init) begin
               mcand_in  = ACC_W'(smag);
               mplier_in = smag;
            end else if (cmd.step) begin
               acc_in    = acc_ff - mul_term;
               mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[SMAG_W-1:1]};
            end
         end
         msd_pkg::OP_SQRT: begin
            if (cmd.init) begin
               rad_in      = div_dq_ff[RAD_W-1:0];
               sq_rem_in   = '0;
               root_in     = '0;
               // a negative n*Q - S*S gives a zero deviation
               stdev_ok_in = !acc_ff[ACC_W-1];
            end else if (cmd.step) begin
               sq_rem_in = sqrt_fit ? sqrt_diff[REM_W-1:0] : sqrt_shift;
               root_in   = {root_ff[ROOT_W-2:0], sqrt_fit};
               rad_in    = {rad_ff[RAD_W-3:0], 2'b00};
            end
         end
         default: begin
         end
      endcase
   end

   // Result capture
   always_comb begin
      out_mean_in  = out_mean_ff;
      out_stdev_in = out_stdev_ff;
      out_used_in  = out_used_ff;
      out_few_in   = out_few_ff;
      out_ovf_in   = out_ovf_ff;
      if (cmd.load_out) begin
         out_mean_in  = mean_ff;
         out_stdev_in = stdev_ok_ff ? root_ff[SAMPLE_W-1:0] : '0;
         out_used_in  = count_ff;
         out_few_in   = (count_ff == CNT_W'(1));
         out_ovf_in   = ovf_ff;
      end
   end

   // Accumulator state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         sqsum_ff   <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         sq_pend_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         sqsum_ff   <= sqsum_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         sq_pend_ff <= sq_pend_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      nn1_ff       <= nn1_in;
      div_dq_ff    <= div_dq_in;
      div_rem_ff   <= div_rem_in;
      div_dvsr_ff  <= div_dvsr_in;
      rad_ff       <= rad_in;
      sq_rem_ff    <= sq_rem_in;
      root_ff      <= root_in;
      stdev_ok_ff  <= stdev_ok_in;
      mean_ff      <= mean_in;
      out_mean_ff  <= out_mean_in;
      out_stdev_ff <= out_stdev_in;
      out_used_ff  <= out_used_in;
      out_few_ff   <= out_few_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_mean_value   = out_mean_ff;
   assign rsp_stdev_value  = out_stdev_ff;
   assign rsp_samples_used = out_used_ff;
   assign rsp_too_few      = out_few_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

`default_nettype wire
